@@ rtl/core/flfr_pkg.sv @@
// ============================================================================
// flfr_pkg
// Shared types and constants for the flag/length frame receiver.
// ============================================================================
package flfr_pkg;

    // Frame layout: start flag, opcode, length, data, checksum, end flag
    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
    localparam logic [7:0] HEADER_LEN     = 8'd3;

    // Register reset values
    localparam logic [7:0] START_FLAG_RST = 8'd105;
    localparam logic [7:0] END_FLAG_RST   = 8'd150;
    localparam logic [7:0] MAX_TOTAL_RST  = 8'd200;

    // Default payload store depth
    localparam int STORE_DEPTH_DEF = 256;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_START_FLAG = 2'd0;
    localparam logic [1:0] REG_END_FLAG   = 2'd1;
    localparam logic [1:0] REG_MAX_TOTAL  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROP    = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;
    localparam logic [1:0] ST_END_ERR = 2'd3;

    // Input request
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_req;

    // Result
    typedef struct packed {
        logic       frame_done;
        logic [1:0] status;
        logic [7:0] opcode;
        logic [7:0] pay_len;
        logic [7:0] check_byte;
        logic [7:0] read_data;
    } t_out_rsp;

    // Configuration registers
    typedef struct packed {
        logic [7:0] sof_byte;
        logic [7:0] eof_byte;
        logic [7:0] max_total_len;
    } t_cfg;

    // Parser step result toward the top level
    typedef struct packed {
        logic       frame_done;
        logic [1:0] status;
        logic [7:0] opcode;
        logic [7:0] pay_len;
        logic [7:0] check_byte;
        logic       wr_en;
        logic [7:0] wr_slot;
    } t_step;

endpackage

@@ rtl/core/flag_length_frame_receiver.sv @@
// ============================================================================
// flag_length_frame_receiver
// Recovers start-flag / opcode / length / data / checksum / end-flag frames
// from received bytes, stores the payload and serves payload reads.
// ============================================================================
//
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_stall   i_in_req  (t_in_req)
//  out      output     o_out_valid / i_out_stall o_out_rsp (t_out_rsp)
//  cfg      input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
//  One request per cycle is accepted while o_in_stall is low; each gives one result
//  through the memory-read stage (payload memory read registered at accept) and the output register.
//  Reset is synchronous, active low; the payload memory is not cleared.
//  A stalled result sits in the output register while one more request is
//  taken into the memory-read stage; only then does o_in_stall rise.
//
module flag_length_frame_receiver #(
    parameter int STORE_DEPTH = flfr_pkg::STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  flfr_pkg::t_in_req  i_in_req,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output flfr_pkg::t_out_rsp o_out_rsp,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int         AW     = $clog2(STORE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

    flfr_pkg::t_cfg     r_cfg;
    flfr_pkg::t_step    step;
    flfr_pkg::t_out_rsp r_s1_rsp;
    flfr_pkg::t_out_rsp r_o_rsp;
    flfr_pkg::t_out_rsp s1_final;
    logic               r_s1_valid;
    logic               r_s1_rd_ok;
    logic               r_o_valid;
    logic [7:0]         r_mem_q;
    logic [7:0]         mem [STORE_DEPTH];
    logic               accept;
    logic               s1_move;
    logic               cfg_wr;
    logic               rd_ok;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sof_byte      <= flfr_pkg::START_FLAG_RST;
            r_cfg.eof_byte      <= flfr_pkg::END_FLAG_RST;
            r_cfg.max_total_len <= flfr_pkg::MAX_TOTAL_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                flfr_pkg::REG_START_FLAG: r_cfg.sof_byte      <= pwdata[7:0];
                flfr_pkg::REG_END_FLAG:   r_cfg.eof_byte      <= pwdata[7:0];
                flfr_pkg::REG_MAX_TOTAL:  r_cfg.max_total_len <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            flfr_pkg::REG_START_FLAG: prdata = {24'd0, r_cfg.sof_byte};
            flfr_pkg::REG_END_FLAG:   prdata = {24'd0, r_cfg.eof_byte};
            flfr_pkg::REG_MAX_TOTAL:  prdata = {24'd0, r_cfg.max_total_len};
            default:                  prdata = 32'd0;
        endcase
    end

    // Pipeline control: memory-read stage feeds the output register
    assign s1_move    = r_s1_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    // Frame parser
    flfr_parse #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_req   (i_in_req),
        .i_cfg   (r_cfg),
        .o_step  (step)
    );

    // Payload store: write at accept, registered read at accept
    assign rd_ok = i_in_req.req_type && ({1'b0, i_in_req.read_index} < DEPTH9);

    always_ff @(posedge i_clk) begin
        if (accept && step.wr_en) begin
            mem[step.wr_slot[AW-1:0]] <= i_in_req.rx_byte;
        end
        if (accept && rd_ok) begin
            r_mem_q <= mem[i_in_req.read_index[AW-1:0]];
        end
    end

    // Memory-read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rsp.frame_done <= step.frame_done;
            r_s1_rsp.status     <= step.status;
            r_s1_rsp.opcode     <= step.opcode;
            r_s1_rsp.pay_len    <= step.pay_len;
            r_s1_rsp.check_byte <= step.check_byte;
            r_s1_rsp.read_data  <= 8'd0;
            r_s1_rd_ok          <= rd_ok;
        end
    end

    always_comb begin
        s1_final           = r_s1_rsp;
        s1_final.read_data = r_s1_rd_ok ? r_mem_q : 8'd0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_rsp <= s1_final;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_rsp   = r_o_rsp;

`ifndef SYNTHESIS
    // a completed frame never carries an error status
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_rsp.frame_done && o_out_rsp.status != flfr_pkg::ST_OK))
        else $error("frame_done with error status");

    // a held result keeps the stage behind it occupied
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_out_stall && r_s1_valid |=> r_s1_valid && r_o_valid)
        else $error("pipeline lost a request under stall");

    // input is only stalled when both stages are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_o_valid)
        else $error("input stalled with free pipeline space");
`endif

endmodule

@@ rtl/core/flfr_parse.sv @@
// ============================================================================
// flfr_parse
// Frame parser: position counter and frame field registers, one byte a step.
// ============================================================================
module flfr_parse #(
    parameter int STORE_DEPTH = flfr_pkg::STORE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  flfr_pkg::t_in_req i_req,
    input  flfr_pkg::t_cfg   i_cfg,
    output flfr_pkg::t_step  o_step
);

    localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_cur_op, n_cur_op;
    logic [7:0] r_cur_len, n_cur_len;
    logic [7:0] r_cur_chk, n_cur_chk;
    logic [7:0] r_done_op, n_done_op;
    logic [7:0] r_done_len, n_done_len;
    logic [7:0] r_done_chk, n_done_chk;

    logic       done;
    logic [1:0] status;
    logic       wr_en;
    logic [7:0] slot;
    logic [8:0] total;
    logic [8:0] data_end;

    assign total    = {1'b0, i_req.rx_byte} + flfr_pkg::FRAME_OVERHEAD;
    assign data_end = {1'b0, flfr_pkg::HEADER_LEN} + {1'b0, r_cur_len};
    assign slot     = r_pos - flfr_pkg::HEADER_LEN;

    // Next-state decode for a received byte
    always_comb begin
        n_pos      = r_pos;
        n_cur_op   = r_cur_op;
        n_cur_len  = r_cur_len;
        n_cur_chk  = r_cur_chk;
        n_done_op  = r_done_op;
        n_done_len = r_done_len;
        n_done_chk = r_done_chk;
        done       = 1'b0;
        status     = flfr_pkg::ST_OK;
        wr_en      = 1'b0;
        if (!i_req.req_type) begin
            if (r_pos == 8'd0) begin
                // hunting for the start flag
                if (i_req.rx_byte == i_cfg.sof_byte) begin
                    n_pos = 8'd1;
                end else begin
                    status = flfr_pkg::ST_DROP;
                end
            end else if (r_pos == 8'd1) begin
                n_cur_op = i_req.rx_byte;
                n_pos    = 8'd2;
            end else if (r_pos == 8'd2) begin
                // length byte, checked against the total limit
                if (total > {1'b0, i_cfg.max_total_len}) begin
                    status    = flfr_pkg::ST_LEN_ERR;
                    n_pos     = 8'd0;
                    n_cur_op  = 8'd0;
                    n_cur_len = 8'd0;
                    n_cur_chk = 8'd0;
                end else begin
                    n_cur_len = i_req.rx_byte;
                    n_pos     = flfr_pkg::HEADER_LEN;
                end
            end else if ({1'b0, r_pos} < data_end) begin
                // payload byte
                wr_en = ({1'b0, slot} < DEPTH9);
                n_pos = r_pos + 8'd1;
            end else if ({1'b0, r_pos} == data_end) begin
                n_cur_chk = i_req.rx_byte;
                n_pos     = r_pos + 8'd1;
            end else begin
                // end flag position
                if (i_req.rx_byte == i_cfg.eof_byte) begin
                    done       = 1'b1;
                    n_done_op  = r_cur_op;
                    n_done_len = r_cur_len;
                    n_done_chk = r_cur_chk;
                end else begin
                    status = flfr_pkg::ST_END_ERR;
                end
                n_pos     = 8'd0;
                n_cur_op  = 8'd0;
                n_cur_len = 8'd0;
                n_cur_chk = 8'd0;
            end
        end
    end

    // State registers, updated on accepted requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 8'd0;
            r_cur_op   <= 8'd0;
            r_cur_len  <= 8'd0;
            r_cur_chk  <= 8'd0;
            r_done_op  <= 8'd0;
            r_done_len <= 8'd0;
            r_done_chk <= 8'd0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_cur_op   <= n_cur_op;
            r_cur_len  <= n_cur_len;
            r_cur_chk  <= n_cur_chk;
            r_done_op  <= n_done_op;
            r_done_len <= n_done_len;
            r_done_chk <= n_done_chk;
        end
    end

    always_comb begin
        o_step.frame_done = done;
        o_step.status     = status;
        o_step.opcode     = n_done_op;
        o_step.pay_len    = n_done_len;
        o_step.check_byte = n_done_chk;
        o_step.wr_en      = wr_en;
        o_step.wr_slot    = slot;
    end

`ifndef SYNTHESIS
    // a rejected frame always returns to hunting
    a_reject_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (o_step.status == flfr_pkg::ST_LEN_ERR ||
                     o_step.status == flfr_pkg::ST_END_ERR) |=> r_pos == 8'd0)
        else $error("parser did not return to hunting after a reject");

    // completion latches the fields of the frame in progress
    a_done_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_step.frame_done |=> r_done_len == $past(r_cur_len) &&
                                          r_done_op == $past(r_cur_op))
        else $error("completed frame fields not latched");

    // position never runs past the end flag slot
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos > 8'd2 |-> {1'b0, r_pos} <= {1'b0, r_cur_len} + 9'd4)
        else $error("byte position beyond frame end");
`endif

endmodule
